// ===== src/jse_pkg.sv =====
// ----------------------------------------------------------------------------
// jse_pkg
// types, constants and helpers shared by the json string escaper
// ----------------------------------------------------------------------------
package jse_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       empty_string;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_end;
        logic       failed;
    } out_item_t;

    typedef struct packed {
        logic latin1_mode;
        logic ascii_only;
    } cfg_t;

    // register indexes of the configuration port
    localparam logic [0:0] CFG_LATIN1_MODE = 1'b0;
    localparam logic [0:0] CFG_ASCII_ONLY  = 1'b1;

    typedef enum logic [1:0] {
        BODY_RAW  = 2'd0,
        BODY_UNIT = 2'd1,
        BODY_FAIL = 2'd2
    } body_kind_t;

    // one queued job: everything one input item expands to
    typedef struct packed {
        logic            open_quote;
        logic            close_quote;
        body_kind_t      kind;
        logic [3:0]      body_len;
        logic [3:0]      total;
        logic [3:0][7:0] data;
    } job_t;

    localparam logic [7:0]  CH_QUOTE  = 8'h22;
    localparam logic [7:0]  CH_BSLASH = 8'h5C;
    localparam logic [7:0]  CH_U      = 8'h75;
    localparam logic [7:0]  CH_B      = 8'h62;
    localparam logic [7:0]  CH_F      = 8'h66;
    localparam logic [7:0]  CH_N      = 8'h6E;
    localparam logic [7:0]  CH_R      = 8'h72;
    localparam logic [7:0]  CH_T      = 8'h74;
    localparam logic [7:0]  CH_NUL    = 8'h00;

    localparam logic [15:0] UNIT_HI_BASE = 16'hD7C0;
    localparam logic [15:0] UNIT_LO_BASE = 16'hDC00;

    localparam logic [3:0]  UNIT_CHARS = 4'd6;

    function automatic logic [7:0] hex_digit(input logic [3:0] d);
        logic [7:0] r;
        if (d > 4'd9)
            r = 8'h57 + {4'b0, d};
        else
            r = 8'h30 + {4'b0, d};
        return r;
    endfunction

endpackage

// ===== src/jse_stream_if.sv =====
// ----------------------------------------------------------------------------
// jse_stream_if
// valid/ready stream channel carrying one payload per transfer
// ----------------------------------------------------------------------------
interface jse_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

// ===== src/jse_front.sv =====
// ----------------------------------------------------------------------------
// jse_front
// accepts input bytes, tracks utf-8 sequence state and classifies each item
// into at most one job for the character queue
// ----------------------------------------------------------------------------
module jse_front import jse_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  cfg_t  cfg,
    jse_stream_if.sink byte_stream,
    input  logic  queue_full,
    output logic  push,
    output job_t  push_job
);

    logic [1:0]      pending_reg;
    logic [2:0]      seq_len_reg;
    logic [20:0]     accum_reg;
    logic [3:0][7:0] raw_reg;
    logic            aborted_reg;

    logic [1:0]      pending_next;
    logic [2:0]      seq_len_next;
    logic [20:0]     accum_next;
    logic [3:0][7:0] raw_next;
    logic            aborted_next;

    logic [7:0]      b;
    logic [7:0]      esc_char;
    logic            bad_cp;
    logic            transfer;
    job_t            job;

    assign byte_stream.ready = !queue_full;
    assign transfer          = byte_stream.valid && !queue_full;
    assign b                 = byte_stream.payload.data_byte;

    always_comb
    begin
        pending_next = pending_reg;
        seq_len_next = seq_len_reg;
        accum_next   = accum_reg;
        raw_next     = raw_reg;
        aborted_next = aborted_reg;
        job          = '0;
        job.kind     = BODY_RAW;
        esc_char     = CH_NUL;
        bad_cp       = 1'b0;

        if (byte_stream.payload.first_byte)
        begin
            pending_next    = 2'd0;
            seq_len_next    = 3'd0;
            aborted_next    = 1'b0;
            job.open_quote  = 1'b1;
        end

        if (!byte_stream.payload.empty_string && !aborted_next)
        begin
            if (pending_next != 2'd0)
            begin
                if (b[7:6] != 2'b10)
                begin
                    aborted_next = 1'b1;
                    pending_next = 2'd0;
                    seq_len_next = 3'd0;
                    job.kind     = BODY_FAIL;
                    job.body_len = 4'd1;
                end
                else
                begin
                    accum_next = {accum_next[14:0], b[5:0]};
                    raw_next[seq_len_next[1:0] - pending_next] = b;
                    pending_next = pending_next - 2'd1;
                    if (pending_next == 2'd0)
                    begin
                        bad_cp = (seq_len_next == 3'd3 && accum_next < 21'h800) ||
                                 (accum_next >= 21'hD800 && accum_next <= 21'hDFFF) ||
                                 (seq_len_next == 3'd4 &&
                                  (accum_next < 21'h10000 || accum_next > 21'h10FFFF));
                        if (bad_cp)
                        begin
                            aborted_next = 1'b1;
                            job.kind     = BODY_FAIL;
                            job.body_len = 4'd1;
                        end
                        else if (cfg.ascii_only ||
                                 (accum_next >= 21'h80 && accum_next <= 21'h9F))
                        begin
                            job.kind = BODY_UNIT;
                            if (accum_next < 21'h10000)
                            begin
                                {job.data[3], job.data[2]} = accum_next[15:0];
                                job.body_len = UNIT_CHARS;
                            end
                            else
                            begin
                                {job.data[3], job.data[2]} =
                                    {5'b0, accum_next[20:10]} + UNIT_HI_BASE;
                                {job.data[1], job.data[0]} =
                                    {6'b0, accum_next[9:0]} + UNIT_LO_BASE;
                                job.body_len = UNIT_CHARS + UNIT_CHARS;
                            end
                        end
                        else
                        begin
                            job.kind     = BODY_RAW;
                            job.data     = raw_next;
                            job.body_len = {1'b0, seq_len_next};
                        end
                        seq_len_next = 3'd0;
                    end
                end
            end
            else
            begin
                unique case (b)
                    8'h22:   esc_char = CH_QUOTE;
                    8'h5C:   esc_char = CH_BSLASH;
                    8'h08:   esc_char = CH_B;
                    8'h0C:   esc_char = CH_F;
                    8'h0A:   esc_char = CH_N;
                    8'h0D:   esc_char = CH_R;
                    8'h09:   esc_char = CH_T;
                    default: esc_char = CH_NUL;
                endcase

                if (esc_char != CH_NUL)
                begin
                    job.kind     = BODY_RAW;
                    job.data[0]  = CH_BSLASH;
                    job.data[1]  = esc_char;
                    job.body_len = 4'd2;
                end
                else if (b <= 8'h1F || b == 8'h7F ||
                         (cfg.latin1_mode && b >= 8'h80 && b <= 8'h9F))
                begin
                    job.kind     = BODY_UNIT;
                    job.data[3]  = 8'h00;
                    job.data[2]  = b;
                    job.body_len = UNIT_CHARS;
                end
                else if (b < 8'h7F || cfg.latin1_mode)
                begin
                    job.kind     = BODY_RAW;
                    job.data[0]  = b;
                    job.body_len = 4'd1;
                end
                else if (b >= 8'hC2 && b <= 8'hDF)
                begin
                    seq_len_next = 3'd2;
                    accum_next   = {16'b0, b[4:0]};
                    raw_next[0]  = b;
                    pending_next = 2'd1;
                end
                else if (b >= 8'hE0 && b <= 8'hEF)
                begin
                    seq_len_next = 3'd3;
                    accum_next   = {17'b0, b[3:0]};
                    raw_next[0]  = b;
                    pending_next = 2'd2;
                end
                else if (b >= 8'hF0 && b <= 8'hF4)
                begin
                    seq_len_next = 3'd4;
                    accum_next   = {18'b0, b[2:0]};
                    raw_next[0]  = b;
                    pending_next = 2'd3;
                end
                else
                begin
                    aborted_next = 1'b1;
                    pending_next = 2'd0;
                    seq_len_next = 3'd0;
                    job.kind     = BODY_FAIL;
                    job.body_len = 4'd1;
                end
            end
        end

        if (byte_stream.payload.last_byte)
        begin
            // truncated sequence at close
            if (!aborted_next && pending_next != 2'd0)
            begin
                job.kind     = BODY_FAIL;
                job.body_len = 4'd1;
            end
            else if (!aborted_next)
                job.close_quote = 1'b1;
            aborted_next = 1'b0;
            pending_next = 2'd0;
            seq_len_next = 3'd0;
        end

        job.total = {3'b0, job.open_quote} + job.body_len + {3'b0, job.close_quote};
    end

    assign push     = transfer && (job.total != 4'd0);
    assign push_job = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            seq_len_reg <= 3'd0;
            accum_reg   <= 21'd0;
            aborted_reg <= 1'b0;
        end
        else if (transfer)
        begin
            pending_reg <= pending_next;
            seq_len_reg <= seq_len_next;
            accum_reg   <= accum_next;
            aborted_reg <= aborted_next;
        end
    end

    // sequence bytes, always written before they are read
    always_ff @(posedge clk)
    begin
        if (transfer)
            raw_reg <= raw_next;
    end

endmodule

// ===== src/jse_queue.sv =====
// ----------------------------------------------------------------------------
// jse_queue
// short job queue between the classifier and the character generator
// ----------------------------------------------------------------------------
module jse_queue import jse_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== src/jse_back.sv =====
// ----------------------------------------------------------------------------
// jse_back
// expands the head job into output characters, one per cycle while the output
// is not stalled, through an output register
// ----------------------------------------------------------------------------
module jse_back import jse_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  job_t head,
    input  logic empty,
    output logic pop,
    jse_stream_if.source char_stream
);

    logic [3:0]  pos_reg;
    logic [3:0]  pos_next;
    logic        valid_reg;
    out_item_t   item_reg;

    logic [3:0]  body_pos;
    logic        unit_sel;
    logic [3:0]  unit_pos;
    logic [15:0] unit;
    logic [7:0]  ch;
    logic        fail_char;
    logic        last_char;
    logic        load;

    assign load      = !empty && (!valid_reg || char_stream.ready);
    assign last_char = (pos_reg == head.total - 4'd1);
    assign pop       = load && last_char;
    assign pos_next  = last_char ? 4'd0 : pos_reg + 4'd1;

    assign body_pos  = pos_reg - {3'b0, head.open_quote};
    assign unit_sel  = (body_pos >= UNIT_CHARS);
    assign unit_pos  = unit_sel ? body_pos - UNIT_CHARS : body_pos;
    assign unit      = unit_sel ? {head.data[1], head.data[0]} : {head.data[3], head.data[2]};

    always_comb
    begin
        ch        = CH_QUOTE;
        fail_char = 1'b0;
        if (head.open_quote && pos_reg == 4'd0)
            ch = CH_QUOTE;
        else if (body_pos < head.body_len)
        begin
            unique case (head.kind)
                BODY_RAW:
                    ch = head.data[body_pos[1:0]];
                BODY_UNIT:
                begin
                    unique case (unit_pos)
                        4'd0:    ch = CH_BSLASH;
                        4'd1:    ch = CH_U;
                        4'd2:    ch = hex_digit(unit[15:12]);
                        4'd3:    ch = hex_digit(unit[11:8]);
                        4'd4:    ch = hex_digit(unit[7:4]);
                        4'd5:    ch = hex_digit(unit[3:0]);
                        default: ch = CH_NUL;
                    endcase
                end
                BODY_FAIL:
                begin
                    ch        = CH_NUL;
                    fail_char = 1'b1;
                end
                default:
                    ch = CH_NUL;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            pos_reg   <= pos_next;
            valid_reg <= 1'b1;
        end
        else if (char_stream.ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.out_char <= ch;
            item_reg.run_end  <= last_char;
            item_reg.failed   <= fail_char;
        end
    end

    assign char_stream.valid   = valid_reg;
    assign char_stream.payload = item_reg;

endmodule

// ===== src/json_string_escaper_top.sv =====
// ----------------------------------------------------------------------------
// json_string_escaper_top
// turns string bytes (latin-1 or utf-8) into a quoted json string literal
//
//   channel      dir   payload                                        flow
//   byte_stream  in    data_byte, first_byte, last_byte, empty_string valid/ready
//   char_stream  out   out_char, run_end, failed                      valid/ready
//   cfg_we/...   in    register index, data                           write only
//
// an input transfer is taken every cycle while the job queue has room
// each input item gives 0 to 13 characters, one per cycle from the generator while not stalled
// a stalled output fills the queue and then holds byte_stream.ready low
// reset clears sequence state, queue and output valid; no clearing pass
// ----------------------------------------------------------------------------
module json_string_escaper_top import jse_pkg::*; #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [0:0] cfg_data,
    jse_stream_if.sink   byte_stream,
    jse_stream_if.source char_stream
);

    cfg_t cfg_reg;
    logic push;
    logic pop;
    logic full;
    logic empty;
    job_t push_job;
    job_t head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LATIN1_MODE: cfg_reg.latin1_mode <= cfg_data[0];
                CFG_ASCII_ONLY:  cfg_reg.ascii_only  <= cfg_data[0];
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    jse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .byte_stream(byte_stream),
        .queue_full (full),
        .push       (push),
        .push_job   (push_job)
    );

    jse_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_job(push_job),
        .pop     (pop),
        .head    (head),
        .full    (full),
        .empty   (empty)
    );

    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .char_stream(char_stream)
    );

endmodule

// ===== src/jse_checker.sv =====
// ----------------------------------------------------------------------------
// jse_checker
// port-level checks on the output channel of the escaper
// ----------------------------------------------------------------------------
module jse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] out_char,
    input logic       run_end,
    input logic       failed
);

    // an error result carries no character
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && failed |-> out_char == 8'h00)
        else $error("error result with nonzero character");

    // an error result ends the run of its item
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && failed |-> run_end)
        else $error("error result without run end");

    // a stalled transfer holds
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable({out_char, run_end, failed}))
        else $error("output changed while stalled");

endmodule

bind json_string_escaper_top jse_checker u_jse_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid   (char_stream.valid),
    .ready   (char_stream.ready),
    .out_char(char_stream.payload.out_char),
    .run_end (char_stream.payload.run_end),
    .failed  (char_stream.payload.failed)
);
